// ----- hdl/stack_machine_executor_top_macros.svh -----
// Assertion macros for the stack machine executor.
`ifndef STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define STACK_MACHINE_EXECUTOR_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define SMX_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SMX_ASSERT_SAME(label, clk, rst, ante, cons)
`define SMX_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/smx_pkg.sv -----
`default_nettype none
package smx_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int PROG_DEPTH  = 256;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int PC_W        = $clog2(PROG_DEPTH);
   localparam int DATA_W      = 32;
   localparam int NEXT_PC_W   = 8;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_STORE  = 3'd1,
      OP_LOAD   = 3'd2,
      OP_PLUS   = 3'd3,
      OP_TIMES  = 3'd4,
      OP_IFZERO = 3'd5,
      OP_DONE   = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      FAULT_NONE  = 2'd0,
      FAULT_UNDER = 2'd1,
      FAULT_OVER  = 2'd2,
      FAULT_RANGE = 2'd3
   } fault_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic merge;
   } stack_ctl_type;

   typedef struct packed {
      logic take_upper;
      logic take_lower;
   } cell_ctl_type;

   typedef struct packed {
      logic [NEXT_PC_W-1:0] next_pc;
      logic [DATA_W-1:0]    reg_value;
      logic                 halted;
      fault_type            fault;
   } result_type;

endpackage
`default_nettype wire

// ----- hdl/smx_cell.sv -----
`default_nettype none
module smx_cell (
   input  wire logic                       clock,
   input  smx_pkg::cell_ctl_type           ctl,
   input  wire logic [smx_pkg::DATA_W-1:0] upper_value,
   input  wire logic [smx_pkg::DATA_W-1:0] lower_value,
   output logic      [smx_pkg::DATA_W-1:0] value
);

   logic [smx_pkg::DATA_W-1:0] value_ff;
   logic [smx_pkg::DATA_W-1:0] value_in;

   always_comb begin
      priority if (ctl.take_upper) begin
         value_in = upper_value;
      end else if (ctl.take_lower) begin
         value_in = lower_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule
`default_nettype wire

// ----- hdl/smx_exec.sv -----
`default_nettype none
module smx_exec (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       accept,
   input  wire logic [2:0]                 operation,
   input  wire logic [smx_pkg::DATA_W-1:0] operand,
   input  wire logic [smx_pkg::DATA_W-1:0] top0,
   input  wire logic [smx_pkg::DATA_W-1:0] top1,
   output smx_pkg::stack_ctl_type          stack_ctl,
   output logic      [smx_pkg::DATA_W-1:0] top_value,
   output smx_pkg::result_type             result
);

   logic [smx_pkg::COUNT_W-1:0] count_ff;
   logic [smx_pkg::COUNT_W-1:0] count_in;
   logic [smx_pkg::PC_W-1:0]    pc_ff;
   logic [smx_pkg::PC_W-1:0]    pc_in;
   logic [smx_pkg::DATA_W-1:0]  data_ff;
   logic [smx_pkg::DATA_W-1:0]  data_in;
   logic [smx_pkg::PC_W-1:0]    pc_next;
   logic [smx_pkg::DATA_W-1:0]  sum;
   logic [smx_pkg::DATA_W-1:0]  product;
   logic                        full;
   logic                        empty;
   logic                        below_two;
   logic                        push;
   logic                        pop;
   logic                        merge;
   logic                        halted;
   smx_pkg::fault_type          fault;
   smx_pkg::op_type             op;

   assign op        = smx_pkg::op_type'(operation);
   assign full      = count_ff >= smx_pkg::COUNT_W'(smx_pkg::STACK_DEPTH);
   assign empty     = count_ff == '0;
   assign below_two = count_ff < smx_pkg::COUNT_W'(2);
   assign sum       = top0 + top1;
   assign product   = top0 * top1;
   assign pc_next   = (pc_ff == smx_pkg::PC_W'(smx_pkg::PROG_DEPTH - 1)) ?
                      '0 : pc_ff + smx_pkg::PC_W'(1);

   always_comb begin
      push      = 1'b0;
      pop       = 1'b0;
      merge     = 1'b0;
      halted    = 1'b0;
      fault     = smx_pkg::FAULT_NONE;
      count_in  = count_ff;
      data_in   = data_ff;
      pc_in     = pc_next;
      top_value = operand;
      unique case (op)
         smx_pkg::OP_PUSH, smx_pkg::OP_LOAD: begin
            if (full) begin
               fault = smx_pkg::FAULT_OVER;
            end else begin
               push      = 1'b1;
               count_in  = count_ff + smx_pkg::COUNT_W'(1);
               top_value = (op == smx_pkg::OP_PUSH) ? operand : data_ff;
            end
         end
         smx_pkg::OP_STORE: begin
            if (empty) begin
               fault = smx_pkg::FAULT_UNDER;
            end else begin
               pop      = 1'b1;
               count_in = count_ff - smx_pkg::COUNT_W'(1);
               data_in  = top0;
            end
         end
         smx_pkg::OP_PLUS, smx_pkg::OP_TIMES: begin
            if (below_two) begin
               fault = smx_pkg::FAULT_UNDER;
            end else begin
               merge     = 1'b1;
               count_in  = count_ff - smx_pkg::COUNT_W'(1);
               top_value = (op == smx_pkg::OP_PLUS) ? sum : product;
            end
         end
         smx_pkg::OP_IFZERO: begin
            if (empty) begin
               fault = smx_pkg::FAULT_UNDER;
            end else if (top0 == '0) begin
               if (operand >= smx_pkg::DATA_W'(smx_pkg::PROG_DEPTH)) begin
                  fault = smx_pkg::FAULT_RANGE;
               end else begin
                  pop      = 1'b1;
                  count_in = count_ff - smx_pkg::COUNT_W'(1);
                  pc_in    = operand[smx_pkg::PC_W-1:0];
               end
            end else begin
               pop      = 1'b1;
               count_in = count_ff - smx_pkg::COUNT_W'(1);
            end
         end
         smx_pkg::OP_DONE: begin
            halted = 1'b1;
            pc_in  = pc_ff;
         end
         default: begin
         end
      endcase
      if (fault != smx_pkg::FAULT_NONE) begin
         pc_in = pc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pc_ff    <= '0;
         data_ff  <= '0;
      end else if (accept) begin
         count_ff <= count_in;
         pc_ff    <= pc_in;
         data_ff  <= data_in;
      end
   end

   assign stack_ctl.push  = accept & push;
   assign stack_ctl.pop   = accept & pop;
   assign stack_ctl.merge = accept & merge;

   assign result.next_pc   = smx_pkg::NEXT_PC_W'(pc_in);
   assign result.reg_value = data_in;
   assign result.halted    = halted;
   assign result.fault     = fault;

endmodule
`default_nettype wire

// ----- hdl/stack_machine_executor_top.sv -----
// Stack machine executor: one instruction per request transaction.
// Request channel: req_valid/req_stall with req_operation and req_operand.
// Response channel: rsp_valid/rsp_stall with rsp_next_pc, rsp_reg_value,
// rsp_halted and rsp_fault, exactly one response per request, in order.
// An instruction executes in the cycle it is accepted; its response is
// registered in the output register, or in the skid register while that is busy.
// Throughput is one instruction per cycle while req_stall is low: the stack is a
// row of cells that all shift in the same cycle, and the top two cells feed the
// adder and the 32x32 multiplier directly.
// A two-entry response buffer (output register plus skid register) lets a
// request be accepted while a finished response waits; req_stall rises only
// when both entries are full, and comes from a register.
// A faulting instruction changes no state and reports its fault code.
// Reset (synchronous, active high) empties the stack, clears the data
// register and the program counter, and drops buffered responses.
`default_nettype none
`include "stack_machine_executor_top_macros.svh"
module stack_machine_executor_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [2:0]                          req_operation,
   input  wire logic signed [smx_pkg::DATA_W-1:0]   req_operand,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [smx_pkg::NEXT_PC_W-1:0]       rsp_next_pc,
   output logic signed [smx_pkg::DATA_W-1:0]        rsp_reg_value,
   output logic                                     rsp_halted,
   output logic      [1:0]                          rsp_fault
);

   logic                       accept;
   logic                       take;
   smx_pkg::stack_ctl_type     stack_ctl;
   logic [smx_pkg::DATA_W-1:0] top_value;
   smx_pkg::result_type        result;
   smx_pkg::cell_ctl_type      cell_ctl [smx_pkg::STACK_DEPTH];
   logic [smx_pkg::DATA_W-1:0] cell_value [smx_pkg::STACK_DEPTH];
   logic [smx_pkg::DATA_W-1:0] upper [smx_pkg::STACK_DEPTH];
   logic [smx_pkg::DATA_W-1:0] lower [smx_pkg::STACK_DEPTH];

   logic                       out_valid_ff;
   logic                       out_valid_in;
   smx_pkg::result_type        out_ff;
   smx_pkg::result_type        out_in;
   logic                       skid_valid_ff;
   logic                       skid_valid_in;
   smx_pkg::result_type        skid_ff;
   smx_pkg::result_type        skid_in;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid & ~skid_valid_ff;
   assign take      = out_valid_ff & ~rsp_stall;

   smx_exec u_exec (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .operation (req_operation),
      .operand   (req_operand),
      .top0      (cell_value[0]),
      .top1      (cell_value[1]),
      .stack_ctl (stack_ctl),
      .top_value (top_value),
      .result    (result)
   );

   for (genvar i = 0; i < smx_pkg::STACK_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign upper[i]               = top_value;
         assign cell_ctl[i].take_upper = stack_ctl.push | stack_ctl.merge;
         assign cell_ctl[i].take_lower = stack_ctl.pop;
      end else begin : g_body
         assign upper[i]               = cell_value[i-1];
         assign cell_ctl[i].take_upper = stack_ctl.push;
         assign cell_ctl[i].take_lower = stack_ctl.pop | stack_ctl.merge;
      end
      if (i == smx_pkg::STACK_DEPTH - 1) begin : g_tail
         assign lower[i] = '0;
      end else begin : g_link
         assign lower[i] = cell_value[i+1];
      end
      smx_cell u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .upper_value (upper[i]),
         .lower_value (lower[i]),
         .value       (cell_value[i])
      );
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_in = result;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff) begin
            skid_in       = result;
            skid_valid_in = 1'b1;
         end else begin
            out_in       = result;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_next_pc   = out_ff.next_pc;
   assign rsp_reg_value = out_ff.reg_value;
   assign rsp_halted    = out_ff.halted;
   assign rsp_fault     = out_ff.fault;

   `SMX_ASSERT_SAME(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   `SMX_ASSERT_SAME(a_halt_no_fault, clock, reset, out_valid_ff && out_ff.halted,
                    out_ff.fault == smx_pkg::FAULT_NONE)
   `SMX_ASSERT_NEXT(a_skid_drains, clock, reset, take && skid_valid_ff, out_valid_ff && !skid_valid_ff)

endmodule
`default_nettype wire

// ----- verif/smx_checker.sv -----
`timescale 1ns / 100ps
module smx_checker (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [2:0]                    req_operation,
   input  wire logic [smx_pkg::DATA_W-1:0]    req_operand,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [smx_pkg::NEXT_PC_W-1:0] rsp_next_pc,
   input  wire logic [smx_pkg::DATA_W-1:0]    rsp_reg_value,
   input  wire logic                          rsp_halted,
   input  wire logic [1:0]                    rsp_fault,
   output int                                 failures,
   output int                                 pending
);

   logic [smx_pkg::DATA_W-1:0] stack_mem [smx_pkg::STACK_DEPTH];
   int unsigned                stack_depth;
   logic [smx_pkg::DATA_W-1:0] data_reg;
   int unsigned                prog_counter;
   smx_pkg::result_type        predicted_rsp [$];

   function automatic smx_pkg::result_type execute_instr(
      logic [2:0] op, logic [smx_pkg::DATA_W-1:0] arg);
      smx_pkg::result_type        res;
      logic [smx_pkg::DATA_W-1:0] top_val;
      logic [smx_pkg::DATA_W-1:0] below_val;
      int unsigned                next_pc;
      smx_pkg::fault_type         flt;
      logic                       halt;
      flt = smx_pkg::FAULT_NONE;
      halt = 1'b0;
      next_pc = (prog_counter + 1) % smx_pkg::PROG_DEPTH;
      case (op)
         smx_pkg::OP_PUSH, smx_pkg::OP_LOAD: begin
            if (stack_depth >= smx_pkg::STACK_DEPTH) begin
               flt = smx_pkg::FAULT_OVER;
            end else begin
               stack_mem[stack_depth] = (op == smx_pkg::OP_PUSH) ? arg : data_reg;
               stack_depth++;
            end
         end
         smx_pkg::OP_STORE: begin
            if (stack_depth < 1) begin
               flt = smx_pkg::FAULT_UNDER;
            end else begin
               stack_depth--;
               data_reg = stack_mem[stack_depth];
            end
         end
         smx_pkg::OP_PLUS, smx_pkg::OP_TIMES: begin
            if (stack_depth < 2) begin
               flt = smx_pkg::FAULT_UNDER;
            end else begin
               top_val = stack_mem[stack_depth - 1];
               below_val = stack_mem[stack_depth - 2];
               stack_depth--;
               if (op == smx_pkg::OP_PLUS) begin
                  stack_mem[stack_depth - 1] = top_val + below_val;
               end else begin
                  stack_mem[stack_depth - 1] = top_val * below_val;
               end
            end
         end
         smx_pkg::OP_IFZERO: begin
            if (stack_depth < 1) begin
               flt = smx_pkg::FAULT_UNDER;
            end else begin
               top_val = stack_mem[stack_depth - 1];
               if (top_val == '0) begin
                  if (arg >= smx_pkg::PROG_DEPTH) begin
                     flt = smx_pkg::FAULT_RANGE;
                  end else begin
                     stack_depth--;
                     next_pc = arg;
                  end
               end else begin
                  stack_depth--;
               end
            end
         end
         smx_pkg::OP_DONE: begin
            halt = 1'b1;
            next_pc = prog_counter;
         end
         default: begin
         end
      endcase
      if (flt != smx_pkg::FAULT_NONE) begin
         next_pc = prog_counter;
      end
      prog_counter = next_pc;
      res.next_pc = smx_pkg::NEXT_PC_W'(prog_counter);
      res.reg_value = data_reg;
      res.halted = halt;
      res.fault = flt;
      return res;
   endfunction

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      smx_pkg::result_type exp_rsp;
      if (reset) begin
         stack_depth = 0;
         data_reg = '0;
         prog_counter = 0;
         predicted_rsp.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_rsp.size() == 0) begin
               failures++;
               $display("%0t: unexpected response pc=%0d reg=%h halted=%0b fault=%0d",
                        $time, rsp_next_pc, rsp_reg_value, rsp_halted, rsp_fault);
            end else begin
               exp_rsp = predicted_rsp.pop_front();
               if (rsp_next_pc !== exp_rsp.next_pc || rsp_reg_value !== exp_rsp.reg_value ||
                   rsp_halted !== exp_rsp.halted || rsp_fault !== exp_rsp.fault) begin
                  failures++;
                  $display({"%0t: mismatch expected pc=%0d reg=%h halted=%0b fault=%0d,",
                            " actual pc=%0d reg=%h halted=%0b fault=%0d"},
                           $time, exp_rsp.next_pc, exp_rsp.reg_value, exp_rsp.halted,
                           exp_rsp.fault, rsp_next_pc, rsp_reg_value, rsp_halted,
                           rsp_fault);
               end
            end
         end
         if (req_valid && !req_stall) begin
            predicted_rsp.push_back(execute_instr(req_operation, req_operand));
         end
      end
      pending = predicted_rsp.size();
   end

endmodule

// ----- verif/tb_stack_machine_executor_top.sv -----
`timescale 1ns / 100ps
module tb_stack_machine_executor_top;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [2:0]                        req_operation;
   logic signed [smx_pkg::DATA_W-1:0] req_operand;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [smx_pkg::NEXT_PC_W-1:0]     rsp_next_pc;
   logic signed [smx_pkg::DATA_W-1:0] rsp_reg_value;
   logic                              rsp_halted;
   logic [1:0]                        rsp_fault;

   int              failures;
   int              pending;
   int              send_idle_pct = 21;
   int              recv_idle_pct = 82;
   int              phase = 0;
   int              items_sent = 0;
   logic            hold_off = 1'b0;
   smx_pkg::op_type drain_ops [4] = '{smx_pkg::OP_STORE, smx_pkg::OP_PLUS,
                                      smx_pkg::OP_TIMES, smx_pkg::OP_IFZERO};

   stack_machine_executor_top DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_reg_value (rsp_reg_value),
      .rsp_halted    (rsp_halted),
      .rsp_fault     (rsp_fault)
   );

   smx_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_operand   (req_operand),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_next_pc   (rsp_next_pc),
      .rsp_reg_value (rsp_reg_value),
      .rsp_halted    (rsp_halted),
      .rsp_fault     (rsp_fault),
      .failures      (failures),
      .pending       (pending)
   );

   always #6 clock = ~clock;

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
      end
   end

   // hold off the response side long enough to back up the request side
   initial begin
      wait (phase == 2);
      repeat (60) @(posedge clock);
      hold_off = 1'b1;
      repeat (200) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb_stack_machine_executor_top: FAIL");
      $finish;
   end

   function automatic logic [smx_pkg::DATA_W-1:0] rand_value();
      case ($urandom_range(5))
         0: return '0;
         1: return smx_pkg::DATA_W'($urandom_range(15));
         2: begin
            case ($urandom_range(3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [smx_pkg::DATA_W-1:0] rand_target();
      case ($urandom_range(6))
         0: return smx_pkg::DATA_W'($urandom_range(32'h7FFF_FFFF, smx_pkg::PROG_DEPTH));
         1: return $urandom | 32'h8000_0000;
         default: return smx_pkg::DATA_W'($urandom_range(smx_pkg::PROG_DEPTH - 1));
      endcase
   endfunction

   task automatic send_instr(logic [2:0] op, logic [smx_pkg::DATA_W-1:0] arg);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_operand <= arg;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic play_sequence();
      int kind;
      int n;
      kind = $urandom_range(99);
      if (kind < 40) begin
         send_instr(smx_pkg::OP_PUSH, rand_value());
         send_instr($urandom_range(1) ? smx_pkg::OP_PUSH : smx_pkg::OP_LOAD, rand_value());
         send_instr($urandom_range(1) ? smx_pkg::OP_PLUS : smx_pkg::OP_TIMES, $urandom);
         case ($urandom_range(2))
            0: send_instr(smx_pkg::OP_STORE, $urandom);
            1: send_instr(smx_pkg::OP_IFZERO, rand_target());
            default: begin
            end
         endcase
      end else if (kind < 57) begin
         send_instr(smx_pkg::OP_PUSH, $urandom_range(1) ? '0 : rand_value());
         send_instr(smx_pkg::OP_IFZERO, rand_target());
      end else if (kind < 67) begin
         n = $urandom_range(18, 6);
         repeat (n) send_instr($urandom_range(3) ? smx_pkg::OP_PUSH : smx_pkg::OP_LOAD,
                               rand_value());
      end else if (kind < 80) begin
         n = $urandom_range(20, 1);
         repeat (n) send_instr(drain_ops[$urandom_range(3)], rand_target());
      end else begin
         send_instr(3'($urandom_range(7)), $urandom);
      end
   endtask

   initial begin
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = smx_pkg::OP_PUSH;
      req_operand = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_instr(smx_pkg::OP_STORE, 32'h0);
      send_instr(smx_pkg::OP_DONE, 32'h0);
      send_instr(3'd7, 32'hFFFF_FFFF);
      send_instr(smx_pkg::OP_PUSH, 32'h7FFF_FFFF);
      send_instr(smx_pkg::OP_PUSH, 32'h8000_0000);
      send_instr(smx_pkg::OP_PLUS, 32'h0);
      send_instr(smx_pkg::OP_STORE, 32'h0);
      send_instr(smx_pkg::OP_PUSH, 32'h0);
      send_instr(smx_pkg::OP_IFZERO, 32'hFFFF_FFFF);
      send_instr(smx_pkg::OP_IFZERO, 32'd255);
      repeat (smx_pkg::STACK_DEPTH) send_instr(smx_pkg::OP_LOAD, 32'h0);
      send_instr(smx_pkg::OP_PUSH, 32'h1234_5678);
      send_instr(smx_pkg::OP_TIMES, 32'h0);

      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin
               send_idle_pct = 21;
               recv_idle_pct = 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct = 21;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         phase = p;
         target = items_sent + 510;
         while (items_sent < target) play_sequence();
      end

      @(negedge clock);
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      repeat (5) @(posedge clock);
      if (failures == 0) begin
         $display("tb_stack_machine_executor_top: PASS");
      end else begin
         $display("tb_stack_machine_executor_top: FAIL");
      end
      $finish;
   end

endmodule
